// File: rtl/taf_pkg.sv
package taf_pkg;

  localparam int WindowLenDefault = 8;
  localparam int DataW = 32;
  localparam int WideW = 48;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegBlend = 3'd0;
  localparam logic [CfgIdxW-1:0] RegB0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegB1 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegB2 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegA1 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegA2 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegArm = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_BQ_CHECK,
    ST_BQ_MUL,
    ST_BQ_DONE,
    ST_WIN,
    ST_DIV,
    ST_DIV_DONE,
    ST_DEV,
    ST_DEV_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [WideW+15:0] multiplicand;
    logic [DataW-1:0]  multiplier;
  } smul_req_t;

endpackage

// File: rtl/taf_serial_mul.sv
module taf_serial_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [63:0] mcand,
  input  logic signed [31:0] mplier,
  output logic busy,
  output logic signed [63:0] product
);
  import taf_pkg::*;

  logic [5:0] count;
  logic signed [63:0] acc;
  logic signed [63:0] shifted;
  logic [31:0] bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 6'd0;
      acc <= '0;
      shifted <= mcand;
      bits <= mplier;
    end else if (busy) begin
      if (count == 6'd31) begin
        acc <= acc - (bits[0] ? shifted : 64'sd0);
      end else begin
        acc <= acc + (bits[0] ? shifted : 64'sd0);
      end
      shifted <= shifted <<< 1;
      bits <= bits >> 1;
      count <= count + 6'd1;
      if (count == 6'd31) begin
        busy <= 1'b0;
      end
    end
  end

  assign product = acc;
endmodule

// File: rtl/taf_serial_div.sv
module taf_serial_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [42:0] dividend,
  input  logic [8:0] divisor,
  output logic busy,
  output logic signed [31:0] quotient
);
  import taf_pkg::*;

  logic [5:0] count;
  logic [42:0] rem_q;
  logic [9:0] part;
  logic neg;
  logic [9:0] trial;
  logic [42:0] mag;
  logic [42:0] qres;

  assign trial = {part[8:0], rem_q[42]};
  assign mag = dividend[42] ? (~dividend + 43'd1) : dividend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
      rem_q <= mag;
      part <= '0;
      neg <= dividend[42];
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        part <= trial - {1'b0, divisor};
        rem_q <= {rem_q[41:0], 1'b1};
      end else begin
        part <= trial;
        rem_q <= {rem_q[41:0], 1'b0};
      end
      count <= count + 6'd1;
      if (count == 6'd42) begin
        busy <= 1'b0;
      end
    end
  end

  assign qres = neg ? (~rem_q + 43'd1) : rem_q;
  assign quotient = qres[31:0];
endmodule

// File: rtl/tilt_angle_filter_chain_core.sv
// Filters three tilt angles per sample: smoothing, biquad and moving average,
// then roll deviation and its saturating running sum. One shared bit-serial
// multiplier and one bit-serial divider do all of the multiplications and
// divisions. An axis whose biquad state is all zero skips the biquad and primes
// that state with its smoothed value. A new input transaction is accepted only
// when idle, so the result waits on the output until it is taken before the next
// sample starts. A clear command is accepted while idle and returns no result.
module tilt_angle_filter_chain_core #(
  parameter int WINDOW_LEN = taf_pkg::WindowLenDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [95:0] s_tdata,   // accel_roll, accel_pitch, accel_yaw
  input  logic s_tuser,          // cmd
  output logic m_tvalid,
  input  logic m_tready,
  output logic [191:0] m_tdata,  // mean_roll, mean_pitch, mean_yaw, deviation, total_deviation
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [taf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [taf_pkg::CfgDataW-1:0] cfg_data
);
  import taf_pkg::*;

  localparam int PosW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CntW = $clog2(WINDOW_LEN + 1);
  localparam int SumW = DataW + CntW + 1;
  localparam logic signed [WideW-1:0] Max48 = {1'b0, {(WideW-1){1'b1}}};
  localparam logic signed [WideW-1:0] Min48 = {1'b1, {(WideW-1){1'b0}}};

  logic [16:0] blend_weight;
  logic signed [31:0] coef [5];
  logic [30:0] arm_length;

  state_t state, state_next;
  logic [1:0] ax;
  logic [3:0] term;
  logic signed [31:0] smooth_angle [3];
  logic signed [31:0] xin1 [3], xin2 [3], yout1 [3], yout2 [3];
  logic signed [31:0] window_store [3][WINDOW_LEN];
  logic [PosW-1:0] write_pos;
  logic [CntW-1:0] fill_count;
  logic signed [SumW-1:0] window_sum [3];
  logic signed [WideW-1:0] deviation_sum;
  logic signed [95:0] samples;
  logic signed [63:0] acc;
  logic signed [31:0] cur;
  logic signed [31:0] avg [3];
  logic signed [WideW-1:0] dev;
  logic signed [31:0] old_val;

  logic mul_start, mul_busy, div_start, div_busy;
  logic signed [63:0] mul_a, product;
  logic signed [31:0] mul_b, quotient;
  logic signed [42:0] div_num;

  taf_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .mcand(mul_a), .mplier(mul_b),
    .busy(mul_busy), .product(product)
  );

  taf_serial_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor({{(9-CntW){1'b0}}, fill_count}), .busy(div_busy), .quotient(quotient)
  );

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= 17'd62259;
      coef[0] <= 32'sh40000000;
      coef[1] <= '0; coef[2] <= '0; coef[3] <= '0; coef[4] <= '0;
      arm_length <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegBlend: blend_weight <= cfg_data[16:0];
        RegB0: coef[0] <= cfg_data;
        RegB1: coef[1] <= cfg_data;
        RegB2: coef[2] <= cfg_data;
        RegA1: coef[3] <= cfg_data;
        RegA2: coef[4] <= cfg_data;
        RegArm: arm_length <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [16:0] w_eff;
  logic signed [31:0] bq_val;
  logic bq_zero;
  logic signed [63:0] rnd_sum;
  logic signed [35:0] y_wide;
  logic signed [WideW:0] tot;
  logic signed [63:0] rnd_dev;

  assign w_eff = blend_weight[16] ? 17'h10000 : blend_weight;
  assign bq_zero = (xin1[ax] == 0) && (xin2[ax] == 0) && (yout1[ax] == 0) &&
                   (yout2[ax] == 0);
  assign rnd_sum = acc + 64'sd134217728;
  assign y_wide = rnd_sum[63:28];
  assign rnd_dev = product + 64'sd32768;
  assign old_val = (fill_count >= CntW'(WINDOW_LEN)) ? window_store[ax][write_pos] : 32'sd0;
  assign tot = {deviation_sum[WideW-1], deviation_sum} + {dev[WideW-1], dev};

  always_comb begin
    case (term[3:1])
      3'd0: bq_val = cur;
      3'd1: bq_val = xin1[ax];
      3'd2: bq_val = xin2[ax];
      3'd3: bq_val = yout1[ax];
      default: bq_val = yout2[ax];
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = s_tuser ? ST_IDLE : ST_SMOOTH;
      ST_SMOOTH: if (term == 4'd4) state_next = ST_BQ_CHECK;
      ST_BQ_CHECK: state_next = bq_zero ? ST_WIN : ST_BQ_MUL;
      ST_BQ_MUL: if (term == 4'd10) state_next = ST_BQ_DONE;
      ST_BQ_DONE: state_next = ST_WIN;
      ST_WIN: state_next = (ax == 2'd2) ? ST_DIV : ST_SMOOTH;
      ST_DIV: if (!div_busy && !div_start && ax == 2'd3) state_next = ST_DEV;
      ST_DEV: if (!mul_busy && !mul_start) state_next = ST_DEV_DONE;
      ST_DEV_DONE: state_next = ST_OUT;
      ST_OUT: if (m_tvalid && m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_num = {{(43-SumW){window_sum[0][SumW-1]}}, window_sum[0]};
    case (state)
      ST_SMOOTH: begin
        mul_start = !mul_busy && !term[0] && (term < 4'd4);
        mul_a = (term == 4'd0) ? 64'(smooth_angle[ax]) : 64'(signed'(samples[31:0]));
        mul_b = (term == 4'd0) ? 32'({15'd0, w_eff}) : 32'(17'h10000 - w_eff);
      end
      ST_BQ_MUL: begin
        mul_start = !mul_busy && !term[0] && (term < 4'd10);
        mul_a = 64'(bq_val);
        mul_b = coef[(term[3:1] > 3'd4) ? 3'd4 : term[3:1]];
      end
      ST_DIV: begin
        div_start = !div_busy && (ax != 2'd3) && !term[0];
        div_num = {{(43-SumW){window_sum[ax][SumW-1]}}, window_sum[ax]};
      end
      ST_DEV: begin
        mul_start = !mul_busy && !term[0];
        mul_a = 64'(avg[0]);
        mul_b = 32'({1'b0, arm_length});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      ax <= '0;
      term <= '0;
      write_pos <= '0;
      fill_count <= '0;
      deviation_sum <= '0;
      for (int i = 0; i < 3; i++) begin
        smooth_angle[i] <= '0; xin1[i] <= '0; xin2[i] <= '0;
        yout1[i] <= '0; yout2[i] <= '0; window_sum[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          ax <= '0;
          term <= '0;
          acc <= 64'sd32768;
          samples <= s_tdata;
          if (s_tvalid && s_tuser) begin
            write_pos <= '0;
            fill_count <= '0;
            for (int i = 0; i < 3; i++) begin
              smooth_angle[i] <= '0; xin1[i] <= '0; xin2[i] <= '0;
              yout1[i] <= '0; yout2[i] <= '0; window_sum[i] <= '0;
            end
          end
        end
        ST_SMOOTH: begin
          if (mul_start) term <= term + 4'd1;
          else if (!mul_busy && term[0]) begin
            acc <= acc + product;
            term <= term + 4'd1;
          end
          if (term == 4'd4) begin
            cur <= acc[47:16];
            smooth_angle[ax] <= acc[47:16];
          end
        end
        ST_BQ_CHECK: begin
          term <= '0;
          acc <= '0;
          if (bq_zero) begin
            xin1[ax] <= cur; xin2[ax] <= cur; yout1[ax] <= cur; yout2[ax] <= cur;
          end
        end
        ST_BQ_MUL: begin
          if (mul_start) term <= term + 4'd1;
          else if (!mul_busy && term[0]) begin
            acc <= (term[3:1] >= 3'd3) ? acc - (product >>> 2) : acc + (product >>> 2);
            term <= term + 4'd1;
          end
        end
        ST_BQ_DONE: begin
          xin2[ax] <= xin1[ax];
          xin1[ax] <= cur;
          yout2[ax] <= yout1[ax];
          if (y_wide > 36'sd2147483647) cur <= 32'h7fffffff;
          else if (y_wide < -36'sd2147483648) cur <= 32'h80000000;
          else cur <= y_wide[31:0];
          if (y_wide > 36'sd2147483647) yout1[ax] <= 32'h7fffffff;
          else if (y_wide < -36'sd2147483648) yout1[ax] <= 32'h80000000;
          else yout1[ax] <= y_wide[31:0];
        end
        ST_WIN: begin
          window_store[ax][write_pos] <= cur;
          window_sum[ax] <= window_sum[ax] - SumW'(old_val) + SumW'(cur);
          samples <= samples >>> 32;
          acc <= 64'sd32768;
          term <= '0;
          if (ax == 2'd2) begin
            ax <= '0;
            write_pos <= (write_pos == PosW'(WINDOW_LEN - 1)) ? '0 : write_pos + 1'b1;
            if (fill_count < CntW'(WINDOW_LEN)) fill_count <= fill_count + 1'b1;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        ST_DIV: begin
          if (div_start) term <= 4'd1;
          else if (!div_busy && term[0]) begin
            avg[ax] <= quotient;
            ax <= ax + 2'd1;
            term <= '0;
          end
        end
        ST_DEV: begin
          if (mul_start) term <= 4'd1;
        end
        ST_DEV_DONE: begin
          dev <= rnd_dev[63:16];
        end
        ST_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            if (tot[WideW] != tot[WideW-1]) deviation_sum <= tot[WideW] ? Min48 : Max48;
            else deviation_sum <= tot[WideW-1:0];
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {deviation_sum, dev, avg[2], avg[1], avg[0]};
endmodule

// File: rtl/taf_checker.sv
module taf_checker (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [191:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken with result pending");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind tilt_angle_filter_chain_core taf_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
